// File: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/smf_pkg.sv
package smf_pkg;

  localparam int unsigned WINDOW_LEN_DEFAULT  = 5;
  localparam int unsigned SAMPLE_BITS_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Occupancy flags of the window queue.
  typedef struct packed {
    logic full;
    logic empty;
  } smf_qstat_t;

endpackage

// File: rtl/smf_front.sv
module smf_front #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  input  logic                                   new_block_i,
  input  logic                                   valid_i,
  input  smf_pkg::smf_qstat_t                    qstat_i,
  output logic                                   stall_o,
  output logic                                   push_o,
  output logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] window_o
);
  import smf_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW_LEN + 1);

  logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] win_q, win_d;
  logic [CntW-1:0]                        fill_q, fill_d;
  logic                                   accept;

  assign stall_o = qstat_i.full;
  assign accept  = valid_i && !qstat_i.full;

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (accept) begin
      win_d[0] = sample_i;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_d[i] = win_q[i-1];
      end
      if (new_block_i) begin
        fill_d = CntW'(1);
      end else if (fill_q < CntW'(WINDOW_LEN)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  // Hand a full window to the queue.
  assign push_o   = accept && (fill_d == CntW'(WINDOW_LEN));
  assign window_o = win_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

endmodule

// File: rtl/smf_queue.sv
module smf_queue #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    rdata_o,
  output smf_pkg::smf_qstat_t qstat_o
);
  import smf_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign qstat_o.full  = (cnt_q == CntW'(DEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign rdata_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/smf_rank.sv
module smf_rank #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  smf_pkg::smf_qstat_t                    qstat_i,
  input  logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] window_i,
  output logic                                   pop_o,
  output logic signed [SAMPLE_BITS-1:0]          median_value_o,
  output logic                                   valid_o,
  input  logic                                   stall_i
);
  import smf_pkg::*;

  localparam int unsigned RankW = $clog2(WINDOW_LEN);

  logic [WINDOW_LEN-1:0][RankW-1:0]       rank;
  logic [WINDOW_LEN-1:0]                  sel_d, sel_q;
  logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] win_q;
  logic                                   s1_valid_q;
  logic                                   s1_ready, out_ready;
  logic [SAMPLE_BITS-1:0]                 med_d, med_q;
  logic                                   out_valid_q;

  // Rank each entry; ties break on position so exactly one entry hits the middle.
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
        if (j != i) begin
          if (($signed(window_i[j]) < $signed(window_i[i])) ||
              ((window_i[j] == window_i[i]) && (j < i))) begin
            rank[i] = rank[i] + 1'b1;
          end
        end
      end
      sel_d[i] = (rank[i] == RankW'(WINDOW_LEN / 2));
    end
  end

  always_comb begin
    med_d = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (sel_q[i]) begin
        med_d = med_d | win_q[i];
      end
    end
  end

  assign out_ready = !out_valid_q || !stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign pop_o     = !qstat_i.empty && s1_ready;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sel_q <= sel_d;
      win_q <= window_i;
    end
    if (s1_valid_q && out_ready) begin
      med_q <= med_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= !qstat_i.empty;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign median_value_o = med_q;
  assign valid_o        = out_valid_q;

endmodule

// File: rtl/sliding_median_filter.sv
// The median of a window-filling word goes via the queue, rank register and output register.
// One word per cycle while stall_o is low; the rank network settles one window per cycle.
// The window queue (QUEUE_DEPTH, default two) takes QUEUE_DEPTH windows before stall_o rises.
// Reset (rst_ni low, asynchronous): window and fill count clear, queue and pipeline empty.
// Words of a block before the window is full produce no result.
module sliding_median_filter #(
  parameter int unsigned WINDOW_LEN  = smf_pkg::WINDOW_LEN_DEFAULT,
  parameter int unsigned SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = smf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          new_block_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  output logic signed [SAMPLE_BITS-1:0] median_value_o,
  output logic                          valid_o,
  input  logic                          stall_i
);
  import smf_pkg::*;

  localparam int unsigned WinBits = WINDOW_LEN * SAMPLE_BITS;

  smf_qstat_t                             qstat;
  logic                                   push, pop;
  logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] front_win, head_win;
  logic [WinBits-1:0]                     head_flat;

  // Front: shift each accepted word into the window, track the block fill,
  // and push a snapshot of the window whenever it is full. Stall on a full queue.
  smf_front #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_i),
    .new_block_i(new_block_i),
    .valid_i    (valid_i),
    .qstat_i    (qstat),
    .stall_o    (stall_o),
    .push_o     (push),
    .window_o   (front_win)
  );

  // Queue: decouple the front from a stalled back end.
  smf_queue #(
    .WIDTH(WinBits),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(front_win),
    .pop_i  (pop),
    .rdata_o(head_flat),
    .qstat_o(qstat)
  );

  assign head_win = head_flat;

  // Back: rank the queued window, select the middle entry, hold it in the
  // output register until the sink takes it.
  smf_rank #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_rank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .window_i      (head_win),
    .pop_o         (pop),
    .median_value_o(median_value_o),
    .valid_o       (valid_o),
    .stall_i       (stall_i)
  );

endmodule

// File: rtl/smf_checker.sv
`include "assert_macros.svh"

module smf_checker #(
  parameter int unsigned SAMPLE_BITS = smf_pkg::SAMPLE_BITS_DEFAULT
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          stall_o,
  input logic signed [SAMPLE_BITS-1:0] median_value_o,
  input logic                          valid_o,
  input logic                          stall_i
);

  // Hold a stalled result.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(median_value_o))

  // An empty output register means the queue has room.
  `ASSERT_IMPL(a_no_stall_when_drained, clk_i, rst_ni, !valid_o, !stall_o)

  // The queue fills only behind a stalled output.
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, $rose(stall_o), $past(valid_o && stall_i))

endmodule

bind sliding_median_filter smf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_smf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .stall_o       (stall_o),
  .median_value_o(median_value_o),
  .valid_o       (valid_o),
  .stall_i       (stall_i)
);
